@@ rtl/bba_pkg.sv @@
// Shared types and constants of the buddy block allocator.
`default_nettype none

package bba_pkg;

	localparam int DEF_MAX_POOL_ORDER  = 16;
	localparam int DEF_MIN_BLOCK_ORDER = 5;

	localparam logic [4:0] POOL_ORDER_RST = 5'd16;
	localparam logic [4:0] HEADER_RST     = 5'd24;

	localparam logic CFG_POOL_ORDER = 1'b0;
	localparam logic CFG_HEADER     = 1'b1;

	typedef enum logic [1:0] {MK_ABSENT, MK_FREE, MK_USED, MK_SPLIT} mark_t;
	typedef enum logic [1:0] {ST_OK, ST_NOSPACE, ST_DOUBLE, ST_INVALID} status_t;
	typedef enum logic {ACT_ALLOC, ACT_FREE} action_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_PREP, OP_READ, OP_READ_SIB, OP_DESCEND_L,
		OP_DESCEND_ADDR, OP_REC_BIG, OP_UP, OP_NEXT, OP_TAKE_BIG, OP_WR_SPLIT,
		OP_WR_LFREE, OP_WR_RFREE_DOWN, OP_GRANT, OP_RELEASE, OP_MERGE_A,
		OP_MERGE_B, OP_MERGE_C, OP_FAIL, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		mark_t mark;
		logic  alloc;
		logic  too_big;
		logic  off_bad;
		logic  idx_zero;
		logic  idx_right;
		logic  o_gt_min;
		logic  o_eq_want;
		logic  o_gt_want;
		logic  have_big;
		logic  start_eq_b;
		logic  start_aligned;
		logic  clearing;
		logic  out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4095
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/bba_datapath.sv @@
// Datapath of the buddy block allocator: tree memory, walk registers, results.
`default_nettype none

module bba_datapath
	import bba_pkg::*;
#(
	parameter int MAX_POOL_ORDER  = DEF_MAX_POOL_ORDER,
	parameter int MIN_BLOCK_ORDER = DEF_MIN_BLOCK_ORDER
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        action,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] user_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  status,
	output logic      [15:0] data_offset,
	output logic      [16:0] block_bytes,
	output logic      [16:0] free_bytes
);

	localparam int NW   = MAX_POOL_ORDER - MIN_BLOCK_ORDER + 1;
	localparam int TREE = (1 << NW) - 1;
	localparam int AW   = MAX_POOL_ORDER;
	localparam int SW   = MAX_POOL_ORDER + 1;
	localparam int OW   = $clog2(MAX_POOL_ORDER + 1);
	localparam int CW   = (MAX_POOL_ORDER + 1 > 17) ? MAX_POOL_ORDER + 1 : 17;
	localparam int EW   = (MAX_POOL_ORDER + 2 > 18) ? MAX_POOL_ORDER + 2 : 18;

	function automatic logic [OW-1:0] clamp_order(input logic [4:0] v);
		logic [OW-1:0] r;
		if (int'(v) < MIN_BLOCK_ORDER) r = OW'(MIN_BLOCK_ORDER);
		else if (int'(v) > MAX_POOL_ORDER) r = OW'(MAX_POOL_ORDER);
		else r = OW'(v);
		return r;
	endfunction

	logic [4:0]    pool_order_q, header_q;
	logic          clr_busy_q;
	logic [NW-1:0] clr_cnt_q;
	logic          action_q;
	logic [16:0]   req_q;
	logic [15:0]   uo_q;
	logic [NW-1:0] idx_q, bg_idx_q;
	logic [OW-1:0] o_q, bg_o_q, want_q;
	logic [AW-1:0] b_q, bg_b_q, start_q;
	logic          big_q, too_big_q, off_bad_q;
	logic [SW-1:0] bytes_free_q;
	status_t       res_status_q;
	logic [15:0]   res_data_q;
	logic [16:0]   res_bsize_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [15:0]   data_offset_q;
	logic [16:0]   block_bytes_q, free_bytes_q;

	logic [OW-1:0] pool_p, want_c;
	logic          fit_c;
	logic [EW-1:0] need_e;
	logic [CW-1:0] start_cw, pool_cw;
	logic          off_bad_c;
	logic [SW-1:0] size_o;
	logic [AW-1:0] size_a, half_a;
	logic [NW-1:0] child_l, child_r, parent, sib;
	logic          ram_we;
	logic [NW-1:0] ram_waddr, ram_raddr;
	mark_t         ram_wdata;
	logic [1:0]    ram_rdata;
	logic          cfg_pool_wr;

	assign pool_p = clamp_order(pool_order_q);
	assign need_e = EW'(req_q) + EW'(header_q);

	// Smallest power of two that holds the request plus header, within the pool.
	always_comb begin
		want_c = OW'(MIN_BLOCK_ORDER);
		fit_c  = 1'b0;
		for (int k = MAX_POOL_ORDER; k >= MIN_BLOCK_ORDER; k--) begin
			if (OW'(k) <= pool_p && need_e <= (EW'(1) << k)) begin
				want_c = OW'(k);
				fit_c  = 1'b1;
			end
		end
	end

	assign start_cw  = CW'(uo_q) - CW'(header_q);
	assign pool_cw   = CW'(1) << pool_p;
	assign off_bad_c = (uo_q < 16'(header_q)) || (start_cw >= pool_cw);

	assign size_o  = SW'(1) << o_q;
	assign size_a  = AW'(size_o);
	assign half_a  = AW'(size_o >> 1);
	assign child_l = NW'({idx_q, 1'b1});
	assign child_r = child_l + NW'(1);
	assign parent  = NW'((idx_q - NW'(1)) >> 1);
	assign sib     = idx_q[0] ? idx_q + NW'(1) : idx_q - NW'(1);

	assign cfg_pool_wr = cfg_valid && cfg_index == CFG_POOL_ORDER;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = MK_ABSENT;
		ram_raddr = idx_q;
		case (cmd.op)
			OP_READ_SIB: ram_raddr = sib;
			OP_WR_SPLIT: begin
				ram_we    = 1'b1;
				ram_wdata = MK_SPLIT;
			end
			OP_WR_LFREE: begin
				ram_we    = 1'b1;
				ram_waddr = child_l;
				ram_wdata = MK_FREE;
			end
			OP_WR_RFREE_DOWN: begin
				ram_we    = 1'b1;
				ram_waddr = child_r;
				ram_wdata = MK_FREE;
			end
			OP_GRANT: begin
				ram_we    = 1'b1;
				ram_wdata = MK_USED;
			end
			OP_RELEASE, OP_MERGE_C: begin
				ram_we    = 1'b1;
				ram_wdata = MK_FREE;
			end
			OP_MERGE_A: ram_we = 1'b1;
			OP_MERGE_B: begin
				ram_we    = 1'b1;
				ram_waddr = sib;
			end
			default: ;
		endcase
		// The clearing pass leaves the root free and every other node absent.
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = (clr_cnt_q == '0) ? MK_FREE : MK_ABSENT;
		end
	end

	bba_ram #(
		.WIDTH(2),
		.DEPTH(TREE)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_order_q <= POOL_ORDER_RST;
			header_q     <= HEADER_RST;
			clr_busy_q   <= 1'b1;
			clr_cnt_q    <= '0;
			bytes_free_q <= SW'(1) << clamp_order(POOL_ORDER_RST);
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + NW'(1);
				if (clr_cnt_q == NW'(TREE - 1)) clr_busy_q <= 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_pool_wr) begin
					pool_order_q <= cfg_data;
					clr_busy_q   <= 1'b1;
					clr_cnt_q    <= '0;
				end else begin
					header_q <= cfg_data;
				end
			end
			if (cfg_pool_wr) begin
				bytes_free_q <= SW'(1) << clamp_order(cfg_data);
			end else if (cmd.op == OP_GRANT) begin
				bytes_free_q <= bytes_free_q - size_o;
			end else if (cmd.op == OP_RELEASE) begin
				bytes_free_q <= bytes_free_q + size_o;
			end
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				action_q <= action;
				req_q    <= request_bytes;
				uo_q     <= user_offset;
				idx_q    <= '0;
				o_q      <= pool_p;
				b_q      <= '0;
				big_q    <= 1'b0;
			end
			OP_PREP: begin
				want_q    <= want_c;
				too_big_q <= !fit_c;
				off_bad_q <= off_bad_c;
				start_q   <= AW'(start_cw);
			end
			OP_DESCEND_L: begin
				idx_q <= child_l;
				o_q   <= o_q - OW'(1);
			end
			OP_DESCEND_ADDR: begin
				if (|(start_q & half_a)) begin
					idx_q <= child_r;
					b_q   <= b_q + half_a;
				end else begin
					idx_q <= child_l;
				end
				o_q <= o_q - OW'(1);
			end
			OP_REC_BIG: begin
				big_q    <= 1'b1;
				bg_idx_q <= idx_q;
				bg_o_q   <= o_q;
				bg_b_q   <= b_q;
			end
			OP_UP: begin
				idx_q <= parent;
				b_q   <= b_q - size_a;
				o_q   <= o_q + OW'(1);
			end
			OP_NEXT: begin
				idx_q <= idx_q + NW'(1);
				b_q   <= b_q + size_a;
			end
			OP_TAKE_BIG: begin
				idx_q <= bg_idx_q;
				o_q   <= bg_o_q;
				b_q   <= bg_b_q;
			end
			OP_WR_RFREE_DOWN: begin
				idx_q <= child_l;
				o_q   <= o_q - OW'(1);
			end
			OP_GRANT: begin
				res_status_q <= ST_OK;
				res_data_q   <= 16'(b_q) + 16'(header_q);
				res_bsize_q  <= 17'(size_o);
			end
			OP_RELEASE: begin
				res_status_q <= ST_OK;
				res_data_q   <= '0;
				res_bsize_q  <= 17'(size_o);
			end
			OP_MERGE_B: idx_q <= parent;
			OP_FAIL: begin
				res_status_q <= cmd.st;
				res_data_q   <= '0;
				res_bsize_q  <= '0;
			end
			OP_EMIT: begin
				status_q      <= res_status_q;
				data_offset_q <= res_data_q;
				block_bytes_q <= res_bsize_q;
				free_bytes_q  <= 17'(bytes_free_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.mark          = mark_t'(ram_rdata);
		sts.alloc         = (action_q == ACT_ALLOC);
		sts.too_big       = too_big_q;
		sts.off_bad       = off_bad_q;
		sts.idx_zero      = (idx_q == '0);
		sts.idx_right     = (idx_q != '0) && !idx_q[0];
		sts.o_gt_min      = (o_q > OW'(MIN_BLOCK_ORDER));
		sts.o_eq_want     = (o_q == want_q);
		sts.o_gt_want     = (o_q > want_q);
		sts.have_big      = big_q;
		sts.start_eq_b    = (start_q == b_q);
		sts.start_aligned = (start_q[MIN_BLOCK_ORDER-1:0] == '0);
		sts.clearing      = clr_busy_q;
		sts.out_free      = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data_offset = data_offset_q;
	assign block_bytes = block_bytes_q;
	assign free_bytes  = free_bytes_q;

endmodule

`default_nettype wire

@@ rtl/bba_ctrl.sv @@
// Controller state machine of the buddy block allocator.
`default_nettype none

module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DISPATCH, S_A_RD, S_A_CK, S_A_NX, S_SPLIT, S_SPL2,
		S_SPL3, S_F_RD, S_F_CK, S_M_RD, S_M_CK, S_M_B, S_M_C, S_FINISH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && !sts.clearing;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		cmd.st  = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.alloc) begin
					if (sts.too_big) begin
						cmd.op  = OP_FAIL;
						cmd.st  = ST_NOSPACE;
						state_d = S_FINISH;
					end else begin
						cmd.op  = OP_READ;
						state_d = S_A_CK;
					end
				end else if (sts.off_bad) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_INVALID;
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_READ;
					state_d = S_F_CK;
				end
			end
			S_A_RD: begin
				cmd.op  = OP_READ;
				state_d = S_A_CK;
			end
			S_A_CK: begin
				if (sts.mark == MK_SPLIT && sts.o_gt_min) begin
					cmd.op  = OP_DESCEND_L;
					state_d = S_A_RD;
				end else if (sts.mark == MK_FREE && sts.o_eq_want) begin
					cmd.op  = OP_GRANT;
					state_d = S_FINISH;
				end else if (sts.mark == MK_FREE && sts.o_gt_want && !sts.have_big) begin
					cmd.op  = OP_REC_BIG;
					state_d = S_A_NX;
				end else begin
					state_d = S_A_NX;
				end
			end
			S_A_NX: begin
				// Climb while on a right child, then step to the next sibling; at the root, take the recorded larger block or fail.
				if (sts.idx_zero) begin
					if (sts.have_big) begin
						cmd.op  = OP_TAKE_BIG;
						state_d = S_SPLIT;
					end else begin
						cmd.op  = OP_FAIL;
						cmd.st  = ST_NOSPACE;
						state_d = S_FINISH;
					end
				end else if (sts.idx_right) begin
					cmd.op = OP_UP;
				end else begin
					cmd.op  = OP_NEXT;
					state_d = S_A_RD;
				end
			end
			S_SPLIT: begin
				if (sts.o_gt_want) begin
					cmd.op  = OP_WR_SPLIT;
					state_d = S_SPL2;
				end else begin
					cmd.op  = OP_GRANT;
					state_d = S_FINISH;
				end
			end
			S_SPL2: begin
				cmd.op  = OP_WR_LFREE;
				state_d = S_SPL3;
			end
			S_SPL3: begin
				cmd.op  = OP_WR_RFREE_DOWN;
				state_d = S_SPLIT;
			end
			S_F_RD: begin
				cmd.op  = OP_READ;
				state_d = S_F_CK;
			end
			S_F_CK: begin
				if (sts.mark == MK_SPLIT && sts.o_gt_min) begin
					cmd.op  = OP_DESCEND_ADDR;
					state_d = S_F_RD;
				end else if (sts.mark == MK_FREE) begin
					cmd.op  = OP_FAIL;
					cmd.st  = (sts.start_eq_b || sts.start_aligned) ? ST_DOUBLE : ST_INVALID;
					state_d = S_FINISH;
				end else if (sts.mark != MK_USED || !sts.start_eq_b) begin
					cmd.op  = OP_FAIL;
					cmd.st  = ST_INVALID;
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_RELEASE;
					state_d = S_M_RD;
				end
			end
			S_M_RD: begin
				if (sts.idx_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_READ_SIB;
					state_d = S_M_CK;
				end
			end
			S_M_CK: begin
				if (sts.mark == MK_FREE) begin
					cmd.op  = OP_MERGE_A;
					state_d = S_M_B;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_M_B: begin
				cmd.op  = OP_MERGE_B;
				state_d = S_M_C;
			end
			S_M_C: begin
				cmd.op  = OP_MERGE_C;
				state_d = S_M_RD;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/buddy_block_allocator.sv @@
// Binary buddy allocator over a power-of-two pool, top level.
//
// Items arrive on the in_valid/in_ready channel: action selects allocate or
// free, with request_bytes or user_offset. Every item gives one result beat on
// out_valid/out_ready: status, data_offset, block_bytes and free_bytes.
// Registers pool_order and header_bytes are written on cfg_valid/cfg_ready,
// which is always ready; writing pool_order empties the pool.
// One item is worked at a time. Allocate scans the tree in address order,
// descending into split nodes, stepping to next siblings and climbing levels,
// then halves a larger free block when no exact fit is found; free descends
// to the addressed block, then merges it with each free buddy. The tree
// memory's read is registered, so each node examined takes a read state
// and a check state.
// After reset and after each pool_order write a clearing pass rewrites all
// 2^(MAX_POOL_ORDER-MIN_BLOCK_ORDER+1)-1 tree nodes (4095 by default);
// in_ready stays low meanwhile.
// A result waits in the output register while out_ready is low; the next item
// is taken meanwhile but its result waits for the register to empty.
`default_nettype none

module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int MAX_POOL_ORDER  = DEF_MAX_POOL_ORDER,
	parameter int MIN_BLOCK_ORDER = DEF_MIN_BLOCK_ORDER
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] user_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  status,
	output logic      [15:0] data_offset,
	output logic      [16:0] block_bytes,
	output logic      [16:0] free_bytes
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bba_datapath #(
		.MAX_POOL_ORDER (MAX_POOL_ORDER),
		.MIN_BLOCK_ORDER(MIN_BLOCK_ORDER)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.request_bytes(request_bytes),
		.user_offset  (user_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.data_offset  (data_offset),
		.block_bytes  (block_bytes),
		.free_bytes   (free_bytes)
	);

	// No item is taken while the tree is being rewritten.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.clearing)
		else $error("item taken during clearing pass");

	// One item at a time: after a beat is taken the input closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input open while an item is in work");

	// An error result carries neither an offset nor a size.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (block_bytes == '0 && data_offset == '0))
		else $error("error result with nonzero payload");

	// A new result is loaded only into an empty or draining output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> (!out_valid || out_ready))
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

@@ test/bba_checker.sv @@
// Checker for the buddy block allocator: tracks the pool, predicts each result and compares.
`timescale 1ns / 1ps

module bba_checker
	import bba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        action,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] user_offset,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [15:0] data_offset,
	input  wire logic [16:0] block_bytes,
	input  wire logic [16:0] free_bytes,
	output int               failures,
	output int               pending
);

	localparam int MAXO  = DEF_MAX_POOL_ORDER;
	localparam int MINO  = DEF_MIN_BLOCK_ORDER;
	localparam int NODES = (1 << (MAXO - MINO + 1)) - 1;

	typedef struct packed {
		status_t     st;
		logic [15:0] offset;
		logic [16:0] blk;
		logic [16:0] avail;
	} alloc_result_t;

	mark_t          node [0:NODES-1];
	int unsigned    pool_free;
	logic [4:0]     order_reg;
	logic [4:0]     hdr_reg;
	alloc_result_t  expected_q[$];

	assign pending = expected_q.size();

	function automatic int pool_log2();
		int p;
		p = order_reg;
		if (p < MINO) p = MINO;
		if (p > MAXO) p = MAXO;
		return p;
	endfunction

	task automatic empty_pool();
		for (int i = 0; i < NODES; i++) node[i] = MK_ABSENT;
		node[0] = MK_FREE;
		pool_free = 1 << pool_log2();
	endtask

	// Walks split nodes down to the block that covers addr.
	task automatic locate_block(input int addr, output int idx, output int o, output int b);
		int nx;
		int half;
		idx = 0;
		o = pool_log2();
		b = 0;
		while (node[idx] == MK_SPLIT && o > MINO) begin
			half = 1 << (o - 1);
			if (addr >= b + half) begin
				nx = 2 * idx + 2;
				b += half;
			end else begin
				nx = 2 * idx + 1;
			end
			if (nx >= NODES) break;
			idx = nx;
			o--;
		end
	endtask

	task automatic predict_item(input logic act, input logic [16:0] req, input logic [15:0] uoff);
		alloc_result_t r;
		int p, pool, need, want, addr, idx, o, b, sib, start;
		int ex_idx, ex_o, ex_b, bg_idx, bg_o, bg_b;
		bit have_exact, have_big;
		p = pool_log2();
		pool = 1 << p;
		r = '0;
		r.st = ST_OK;
		if (act == ACT_ALLOC) begin
			need = int'(hdr_reg) + int'(req);
			want = MINO;
			while (want <= p && (1 << want) < need) want++;
			if (want > p) begin
				r.st = ST_NOSPACE;
			end else begin
				have_exact = 0;
				have_big = 0;
				addr = 0;
				while (addr < pool && !have_exact) begin
					locate_block(addr, idx, o, b);
					if (node[idx] == MK_FREE) begin
						if (o == want) begin
							have_exact = 1;
							ex_idx = idx; ex_o = o; ex_b = b;
						end else if (o > want && !have_big) begin
							have_big = 1;
							bg_idx = idx; bg_o = o; bg_b = b;
						end
					end
					addr = b + (1 << o);
				end
				if (!have_exact && have_big) begin
					ex_idx = bg_idx; ex_o = bg_o; ex_b = bg_b;
					// Halve repeatedly, always keeping the lower half.
					while (ex_o > want && 2 * ex_idx + 2 < NODES) begin
						node[ex_idx] = MK_SPLIT;
						node[2 * ex_idx + 1] = MK_FREE;
						node[2 * ex_idx + 2] = MK_FREE;
						ex_idx = 2 * ex_idx + 1;
						ex_o--;
					end
					have_exact = 1;
				end
				if (have_exact) begin
					node[ex_idx] = MK_USED;
					r.blk = 17'(1 << ex_o);
					pool_free -= (1 << ex_o);
					r.offset = 16'(ex_b + int'(hdr_reg));
				end else begin
					r.st = ST_NOSPACE;
				end
			end
		end else begin
			if (int'(uoff) < int'(hdr_reg) || int'(uoff) - int'(hdr_reg) >= pool) begin
				r.st = ST_INVALID;
			end else begin
				start = int'(uoff) - int'(hdr_reg);
				locate_block(start, idx, o, b);
				if (node[idx] == MK_FREE) begin
					if (b == start || (start & ((1 << MINO) - 1)) == 0) r.st = ST_DOUBLE;
					else r.st = ST_INVALID;
				end else if (node[idx] != MK_USED || b != start) begin
					r.st = ST_INVALID;
				end else begin
					r.blk = 17'(1 << o);
					pool_free += (1 << o);
					node[idx] = MK_FREE;
					while (idx != 0) begin
						sib = (idx & 1) ? idx + 1 : idx - 1;
						if (node[sib] != MK_FREE) break;
						node[idx] = MK_ABSENT;
						node[sib] = MK_ABSENT;
						idx = (idx - 1) / 2;
						node[idx] = MK_FREE;
					end
				end
			end
		end
		r.avail = 17'(pool_free);
		expected_q.push_back(r);
	endtask

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		failures++;
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			order_reg = POOL_ORDER_RST;
			hdr_reg = HEADER_RST;
			expected_q.delete();
			empty_pool();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("result beat with no item outstanding");
				end else begin
					e = expected_q.pop_front();
					if (status !== e.st)
						report($sformatf("status %0d, expected %0d", status, e.st));
					if (data_offset !== e.offset)
						report($sformatf("data_offset %0d, expected %0d", data_offset, e.offset));
					if (block_bytes !== e.blk)
						report($sformatf("block_bytes %0d, expected %0d", block_bytes, e.blk));
					if (free_bytes !== e.avail)
						report($sformatf("free_bytes %0d, expected %0d", free_bytes, e.avail));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POOL_ORDER) begin
					order_reg = cfg_data;
					empty_pool();
				end else begin
					hdr_reg = cfg_data;
				end
			end
			if (in_valid && in_ready) predict_item(action, request_bytes, user_offset);
		end
	end

endmodule

@@ test/testbench.sv @@
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import bba_pkg::*;

	localparam int LIMIT = 100_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [16:0] request_bytes;
	logic [15:0] user_offset;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] data_offset;
	logic [16:0] block_bytes;
	logic [16:0] free_bytes;
	int          failures;
	int          pending;

	int          cycles;
	int          n_sent;
	int          n_done;
	bit          calm;
	bit          hold_go;
	int          pool_log;
	logic [15:0] live_offsets[$];
	logic        sent_actions[$];

	buddy_block_allocator u_top (.*);

	bba_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		int hold_cnt;
		if (hold_go && hold_cnt < 400) begin
			hold_cnt++;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
		end
	end

	// Harvest granted offsets so that later frees are mostly well formed.
	always @(posedge clk) begin
		logic act;
		if (out_valid && out_ready && sent_actions.size() > 0) begin
			act = sent_actions.pop_front();
			n_done++;
			if (act == ACT_ALLOC && status == ST_OK) live_offsets.push_back(data_offset);
		end
	end

	task automatic pause_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(input logic act, input logic [16:0] req, input logic [15:0] uoff);
		if (!calm && $urandom_range(0, 99) < 14) pause_sender($urandom_range(1, 6));
		in_valid <= 1'b1;
		action <= act;
		request_bytes <= req;
		user_offset <= uoff;
		sent_actions.push_back(act);
		n_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		pause_sender(1);
		while (n_done != n_sent) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_POOL_ORDER) begin
			live_offsets.delete();
			pool_log = (value < DEF_MIN_BLOCK_ORDER) ? DEF_MIN_BLOCK_ORDER :
				(value > DEF_MAX_POOL_ORDER) ? DEF_MAX_POOL_ORDER : int'(value);
		end
	endtask

	task automatic random_item();
		int k;
		int pick;
		logic [15:0] uoff;
		if (live_offsets.size() == 0 || $urandom_range(0, 99) < (live_offsets.size() < 8 ? 70 : 45)) begin
			if ($urandom_range(0, 99) < 5) begin
				send_item(ACT_ALLOC, 17'($urandom), '0);
			end else begin
				k = $urandom_range(0, pool_log);
				send_item(ACT_ALLOC, 17'($urandom_range(0, 1 << k)), '0);
			end
		end else if ($urandom_range(0, 99) < 80) begin
			pick = $urandom_range(0, live_offsets.size() - 1);
			uoff = live_offsets[pick];
			live_offsets.delete(pick);
			// Now and then a free that is slightly off, or repeated.
			if ($urandom_range(0, 9) == 0) uoff = uoff + 16'($urandom_range(0, 40)) - 16'd20;
			else if ($urandom_range(0, 9) == 0) live_offsets.push_back(uoff);
			send_item(ACT_FREE, 17'($urandom), uoff);
		end else begin
			send_item(ACT_FREE, 17'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [4:0] orders [6];
		logic [4:0] hdrs [6];
		orders = '{5'd0, 5'd31, 5'd6, 5'd10, 5'd16, 5'd12};
		hdrs   = '{5'd0, 5'd31, 5'd31, 5'd8, 5'd0, 5'd17};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POOL_ORDER;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		request_bytes = '0;
		user_offset = '0;
		out_ready = 1'b0;
		cycles = 0;
		n_sent = 0;
		n_done = 0;
		calm = 1'b0;
		hold_go = 1'b0;
		pool_log = POOL_ORDER_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items on the reset configuration: pool of 64 KiB, header 24.
		send_item(ACT_ALLOC, 17'd0, '0);
		send_item(ACT_ALLOC, 17'd65536, '0);
		send_item(ACT_ALLOC, 17'h1FFFF, '0);
		send_item(ACT_ALLOC, 17'd100, '0);
		send_item(ACT_ALLOC, 17'd1000, '0);
		send_item(ACT_ALLOC, 17'd65512, '0);
		send_item(ACT_FREE, '0, 16'd0);
		send_item(ACT_FREE, '0, 16'd23);
		send_item(ACT_FREE, '0, 16'hFFFF);
		send_item(ACT_FREE, '0, 16'd24);
		send_item(ACT_FREE, '0, 16'd24);
		send_item(ACT_FREE, '0, 16'd64 + 16'd24);
		send_item(ACT_FREE, '0, 16'd32 + 16'd24);
		send_item(ACT_FREE, '0, 16'd1024 + 16'd24 + 16'd8);
		send_item(ACT_FREE, '0, 16'd1024 + 16'd24);
		send_item(ACT_FREE, '0, 16'd1024 + 16'd24);
		send_item(ACT_ALLOC, 17'd8, '0);
		drain();
		live_offsets.delete();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_POOL_ORDER, orders[ph]);
			write_reg(CFG_HEADER, hdrs[ph]);
			calm = (ph == 4);
			if (ph == 1) hold_go <= 1'b1;
			for (int i = 0; i < 140; i++) begin
				// Mid-phase header change with blocks still in use.
				if (ph == 3 && i == 70) write_reg(CFG_HEADER, 5'd12);
				random_item();
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
